### sv/hmp_pkg.sv
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types and constants for the hash message padder.
// ----------------------------------------------------------------------------
package hmp_pkg;

  localparam int FILL_W  = 7;
  localparam int TOTAL_W = 61;
  localparam int WORD_W  = 64;
  localparam int WIDX_W  = 3;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_FINISH = 1'b1;
  localparam logic [7:0] BYTE_MARK = 8'h80;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef enum logic [2:0] {
    J_FLUSH_APP,
    J_FLUSH_FIN,
    J_SPILL,
    J_LAST,
    J_TAIL
  } job_t;

  typedef struct packed {
    logic              en;
    logic [FILL_W-1:0] pos;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic              ld;
    logic [WIDX_W-1:0] word;
    logic [FILL_W-1:0] data_lim;
    logic              mark_en;
    logic              len_en;
    logic              fin;
    logic              last;
  } ctl_t;

endpackage

### sv/hmp_if.sv
// ----------------------------------------------------------------------------
// hmp_in_if / hmp_out_if
// Valid/ready channels for message items and block words.
// ----------------------------------------------------------------------------
interface hmp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface hmp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_word;
  logic [2:0]  word_index;
  logic        block_end;
  logic        message_end;

  modport source (output valid, output block_word, output word_index,
                  output block_end, output message_end, input ready);
  modport sink   (input valid, input block_word, input word_index,
                  input block_end, input message_end, output ready);
endinterface

### sv/hmp_buffer.sv
// ----------------------------------------------------------------------------
// hmp_buffer
// Word-wide block memory. Bytes are merged into the current word and the
// whole word is written back; reads are registered.
// ----------------------------------------------------------------------------
module hmp_buffer import hmp_pkg::*; #(
  parameter int WORDS = 8,
  parameter int AW    = 3
) (
  input  logic              clk,
  input  wr_t               wr,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] acc_nxt;
  logic [WORD_W-1:0] rd_data_r;
  logic [2:0]        lane;

  always_comb begin
    lane    = wr.pos[2:0];
    acc_nxt = (lane == 3'd0) ? '0 : acc_r;
    acc_nxt[{~lane, 3'b000} +: 8] = wr.data;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.pos[AW+2:3]] <= acc_nxt;
      acc_r               <= acc_nxt;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/hmp_word_gen.sv
// ----------------------------------------------------------------------------
// hmp_word_gen
// Builds each output word from buffer data, the end marker and the length
// bytes, and holds it in the output register.
// ----------------------------------------------------------------------------
module hmp_word_gen import hmp_pkg::*; #(
  parameter int BLOCK_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  input  logic [WORD_W-1:0]  rd_data,
  input  logic [TOTAL_W-1:0] total,
  input  logic               len_le,
  output logic               can_load,
  hmp_out_if.source          out_ch
);

  localparam logic [FILL_W-1:0] BS     = FILL_W'(BLOCK_BYTES);
  localparam logic [FILL_W-1:0] LEN_AT = FILL_W'(BLOCK_BYTES - 8);

  logic                valid_r;
  logic [WORD_W-1:0]   word_r;
  logic [WORD_W-1:0]   word_nxt;
  logic [WIDX_W-1:0]   widx_r;
  logic                bend_r;
  logic                mend_r;
  logic [WORD_W-1:0]   bits;

  assign bits     = {total, 3'b000};
  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    logic [FILL_W-1:0] idx;
    logic [FILL_W-1:0] li;
    logic [2:0]        sh;
    logic [7:0]        b;
    word_nxt = '0;
    for (int k = 0; k < 8; k++) begin
      idx = FILL_W'({ctl.word, 3'(k)});
      li  = idx - LEN_AT;
      sh  = len_le ? li[2:0] : ~li[2:0];
      if (idx >= BS) begin
        b = BYTE_ZERO;
      end else if (idx < ctl.data_lim) begin
        b = rd_data[WORD_W-1-8*k -: 8];
      end else if (ctl.mark_en && idx == ctl.data_lim) begin
        b = BYTE_MARK;
      end else if (ctl.len_en && idx >= LEN_AT) begin
        b = bits[{sh, 3'b000} +: 8];
      end else begin
        b = BYTE_ZERO;
      end
      word_nxt[WORD_W-1-8*k -: 8] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= ctl.ld;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && ctl.ld) begin
      word_r <= word_nxt;
      widx_r <= ctl.word;
      bend_r <= ctl.last;
      mend_r <= ctl.last && ctl.fin;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.block_word  = word_r;
  assign out_ch.word_index  = widx_r;
  assign out_ch.block_end   = bend_r;
  assign out_ch.message_end = mend_r;

endmodule

### sv/hmp_seq.sv
// ----------------------------------------------------------------------------
// hmp_seq
// Sequencer: takes message beats, keeps the fill count and byte total, and
// walks the block memory word by word for flushes and padding.
// ----------------------------------------------------------------------------
module hmp_seq import hmp_pkg::*; #(
  parameter int BLOCK_BYTES = 64,
  parameter int WORDS       = 8,
  parameter int AW          = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  hmp_in_if.sink             in_ch,
  input  logic               can_load,
  output wr_t                wr,
  output logic [AW-1:0]      rd_addr,
  output ctl_t               ctl,
  output logic [TOTAL_W-1:0] total
);

  localparam logic [FILL_W-1:0] BS     = FILL_W'(BLOCK_BYTES);
  localparam logic [FILL_W-1:0] LEN_AT = FILL_W'(BLOCK_BYTES - 8);
  localparam logic [AW-1:0]     LAST_W = AW'(WORDS - 1);

  state_t             state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [AW-1:0]      word_r, word_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [7:0]         held_r, held_nxt;
  logic               acc_in;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign rd_addr     = word_r;
  assign total       = total_r;

  always_comb begin
    ctl.ld       = (state_r == ST_LOAD);
    ctl.word     = WIDX_W'(word_r);
    ctl.last     = (word_r == LAST_W);
    ctl.mark_en  = (job_r == J_SPILL) || (job_r == J_LAST);
    ctl.len_en   = (job_r == J_LAST) || (job_r == J_TAIL);
    ctl.fin      = ctl.len_en;
    case (job_r)
      J_FLUSH_APP: ctl.data_lim = BS;
      J_FLUSH_FIN: ctl.data_lim = BS;
      J_TAIL:      ctl.data_lim = '0;
      default:     ctl.data_lim = fill_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    word_nxt  = word_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    held_nxt  = held_r;
    wr        = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          word_nxt = '0;
          if (in_ch.operation == OP_APPEND) begin
            total_nxt = total_r + 1'b1;
            if (fill_r >= BS) begin
              held_nxt  = in_ch.data_byte;
              job_nxt   = J_FLUSH_APP;
              state_nxt = ST_READ;
            end else begin
              wr.en    = 1'b1;
              wr.pos   = fill_r;
              wr.data  = in_ch.data_byte;
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            state_nxt = ST_READ;
            if (fill_r >= BS) begin
              job_nxt = J_FLUSH_FIN;
            end else if (fill_r >= LEN_AT) begin
              job_nxt = J_SPILL;
            end else begin
              job_nxt = J_LAST;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (can_load) begin
          if (word_r == LAST_W) begin
            word_nxt = '0;
            case (job_r)
              J_FLUSH_APP: begin
                wr.en     = 1'b1;
                wr.pos    = '0;
                wr.data   = held_r;
                fill_nxt  = FILL_W'(1);
                state_nxt = ST_IDLE;
              end
              J_FLUSH_FIN: begin
                fill_nxt  = '0;
                job_nxt   = J_LAST;
                state_nxt = ST_READ;
              end
              J_SPILL: begin
                job_nxt   = J_TAIL;
                state_nxt = ST_READ;
              end
              default: begin
                fill_nxt  = '0;
                total_nxt = '0;
                state_nxt = ST_IDLE;
              end
            endcase
          end else begin
            word_nxt  = word_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= J_LAST;
      word_r  <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      word_r  <= word_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= BS)
    else $error("fill count beyond block size");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld && ctl.last && ctl.fin && can_load |=> fill_r == '0 && total_r == '0)
    else $error("message state not cleared after final block");

  a_mark_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld && ctl.mark_en && ctl.len_en |-> ctl.data_lim < LEN_AT)
    else $error("end marker overlaps length field");

  a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_ch.operation == OP_APPEND && fill_r >= BS
    |=> state_r == ST_READ && job_r == J_FLUSH_APP && word_r == '0)
    else $error("full block not flushed before append");

endmodule

### sv/hash_message_padder.sv
// ----------------------------------------------------------------------------
// hash_message_padder
// Collects message bytes into blocks, emits each block as 64-bit words and
// appends the end marker, zero fill and bit length on a finish beat.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_ch    in   operation, data_byte
//  out_ch   out  block_word, word_index, block_end, message_end
//  cfg_*    in   length byte order, one bit
//
//  An append beat into a block with room is written to the block memory from the idle state.
//  Each emitted word passes through a read state, set by the registered read of the
//  block memory, and then a load state into the output register.
//  A finish beat emits one or two blocks, an append on a full block one.
//  Reset clears the fill count, byte total and byte order, not the block memory.
//  A stalled output holds the word in the output register and pauses the walk.
// ----------------------------------------------------------------------------
module hash_message_padder import hmp_pkg::*; #(
  parameter int BLOCK_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  hmp_in_if.sink    in_ch,
  hmp_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int WORDS = (BLOCK_BYTES + 7) / 8;
  localparam int AW    = $clog2(WORDS);

  logic               cfg_le_r;
  logic               can_load;
  wr_t                wr;
  ctl_t               ctl;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic [TOTAL_W-1:0] total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_le_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_le_r <= cfg_wr_data;
    end
  end

  hmp_seq #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .WORDS       (WORDS),
    .AW          (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .can_load (can_load),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .ctl      (ctl),
    .total    (total)
  );

  hmp_buffer #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_buffer (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hmp_word_gen #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_word_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_data  (rd_data),
    .total    (total),
    .len_le   (cfg_le_r),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
